@@ rtl/core/tfn_pkg.sv @@
`default_nettype none
package tfn_pkg;

    localparam int COMP_W = 16;
    localparam int SUM_W  = 32;  // a^2 + b^2 reaches 2^31 for two -32768 inputs
    localparam int ROOT_W = 16;  // floor(sqrt) of the sum
    localparam int SQ_STEPS = 16;
    localparam int QUO_W  = 32;  // quotient width before saturation

    typedef logic signed [COMP_W-1:0] comp_t;

    // Item context that rides along the cell row
    typedef struct packed {
        logic  three_dim;
        logic  xy_branch;
        comp_t nx;
        comp_t ny;
        comp_t nz;
    } ctx_t;

    function automatic comp_t sat16(input logic signed [47:0] v);
        comp_t r;
        if (v > 48'sd32767)
            r = 16'sh7fff;
        else if (v < -48'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/tangent_frame_from_normal_unit.sv @@
`default_nettype none
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata[47:0] = normal_x, normal_y, normal_z
// m_axis   | out | tdata[95:0] = tangent1_x..z, tangent2_x..z; tuser = degenerate
// cfg      | in  | cfg_wr_en / cfg_wr_data[0] = three_dim_mode
// One beat per cycle while the output is not stalled; beats pass through the
// square root cells, the divide cells and the cross-product stages.
// The whole cell row advances together; an output stall holds the row
// (ready drops only while the output register is full and not taken).
// Reset clears valid flags and sets three_dim_mode to 1.
module tangent_frame_from_normal_unit
#(
    parameter int FRAC_BITS = 14
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // normal_x, normal_y, normal_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // t1_x, t1_y, t1_z, t2_x, t2_y, t2_z
    output logic             m_axis_tuser    // degenerate
);
    import tfn_pkg::*;

    localparam int DIV_STEPS = QUO_W;
    localparam logic [COMP_W-1:0] HALF = COMP_W'(1) << (FRAC_BITS - 1);

    logic en;
    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // row advances unless the final stage holds a beat that is not taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 0: capture, branch select, sum of squares
    ctx_t              ctx0;
    logic              v0_reg;
    ctx_t              c0_reg;
    logic [SUM_W-1:0]  sum0_reg;
    logic [COMP_W:0]   ax;
    logic [COMP_W:0]   ay;
    logic              xy;
    logic signed [COMP_W-1:0] pa;
    logic signed [COMP_W-1:0] pb;

    always_comb
    begin
        ctx0.nx = s_axis_tdata[15:0];
        ctx0.ny = s_axis_tdata[31:16];
        ctx0.nz = s_axis_tdata[47:32];
        ax = ctx0.nx[15] ? (COMP_W+1)'(-{ctx0.nx[15], ctx0.nx})
                         : {1'b0, ctx0.nx};
        ay = ctx0.ny[15] ? (COMP_W+1)'(-{ctx0.ny[15], ctx0.ny})
                         : {1'b0, ctx0.ny};
        xy = (ax >= {1'b0, HALF}) || (ay >= {1'b0, HALF});
        ctx0.three_dim = mode_reg;
        ctx0.xy_branch = xy;
        pa = xy ? ctx0.nx : ctx0.ny;
        pb = xy ? ctx0.ny : ctx0.nz;
    end

    logic signed [31:0] sq_a_reg;
    logic signed [31:0] sq_b_reg;
    logic               v1_reg;
    ctx_t               c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
        end
    end

    // squares registered, then summed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg   <= ctx0;
            sq_a_reg <= pa * pa;
            sq_b_reg <= pb * pb;
            c1_reg   <= c0_reg;
            sum0_reg <= SUM_W'(sq_a_reg + sq_b_reg);
        end
    end

    // ---- square root cell row
    logic              sv [SQ_STEPS+1];
    logic [SUM_W-1:0]  sr [SQ_STEPS+1];
    logic [ROOT_W-1:0] sq [SQ_STEPS+1];
    ctx_t              sc [SQ_STEPS+1];

    assign sv[0] = v1_reg;
    assign sr[0] = sum0_reg;
    assign sq[0] = '0;
    assign sc[0] = c1_reg;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        tfn_sqrt_cell #(.STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(sv[g]), .in_rem(sr[g]), .in_root(sq[g]), .in_ctx(sc[g]),
            .out_valid(sv[g+1]), .out_rem(sr[g+1]), .out_root(sq[g+1]),
            .out_ctx(sc[g+1])
        );
    end

    // ---- numerators: |c| << FRAC_BITS + len/2
    ctx_t               sctx;
    logic signed [COMP_W-1:0] ca;
    logic signed [COMP_W-1:0] cb;
    logic [COMP_W:0]    ma;
    logic [COMP_W:0]    mb;
    logic [QUO_W-1:0]   na;
    logic [QUO_W-1:0]   nb;
    logic [ROOT_W-1:0]  len;

    always_comb
    begin
        sctx = sc[SQ_STEPS];
        len  = sq[SQ_STEPS];
        // xy: a = ny, b = -nx ; yz: a = -nz, b = ny  (b taken as signed pair)
        ca = sctx.xy_branch ? sctx.ny : sctx.nz;
        cb = sctx.xy_branch ? sctx.nx : sctx.ny;
        ma = ca[15] ? (COMP_W+1)'(-{ca[15], ca}) : {1'b0, ca};
        mb = cb[15] ? (COMP_W+1)'(-{cb[15], cb}) : {1'b0, cb};
        na = (QUO_W'(ma) << FRAC_BITS) + QUO_W'(len >> 1);
        nb = (QUO_W'(mb) << FRAC_BITS) + QUO_W'(len >> 1);
    end

    logic              dv [DIV_STEPS+1];
    logic [ROOT_W-1:0] dl [DIV_STEPS+1];
    logic [QUO_W-1:0]  dna [DIV_STEPS+1];
    logic [QUO_W-1:0]  dnb [DIV_STEPS+1];
    logic [QUO_W-1:0]  dqa [DIV_STEPS+1];
    logic [QUO_W-1:0]  dqb [DIV_STEPS+1];
    ctx_t              dc [DIV_STEPS+1];

    assign dv[0]  = sv[SQ_STEPS];
    assign dl[0]  = len;
    assign dna[0] = na;
    assign dnb[0] = nb;
    assign dqa[0] = '0;
    assign dqb[0] = '0;
    assign dc[0]  = sctx;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        tfn_div_cell #(.STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(dv[g]), .in_len(dl[g]), .in_num_a(dna[g]), .in_num_b(dnb[g]),
            .in_q_a(dqa[g]), .in_q_b(dqb[g]), .in_ctx(dc[g]),
            .out_valid(dv[g+1]), .out_len(dl[g+1]), .out_num_a(dna[g+1]),
            .out_num_b(dnb[g+1]), .out_q_a(dqa[g+1]), .out_q_b(dqb[g+1]),
            .out_ctx(dc[g+1])
        );
    end

    // ---- tangent one: sign and saturate
    ctx_t  dctx;
    comp_t qa_s;
    comp_t qb_s;
    comp_t u_a;
    comp_t u_b;
    logic signed [47:0] qa_ext;
    logic signed [47:0] qb_ext;

    always_comb
    begin
        dctx   = dc[DIV_STEPS];
        qa_ext = 48'($signed({1'b0, dqa[DIV_STEPS]}));
        qb_ext = 48'($signed({1'b0, dqb[DIV_STEPS]}));
        // a carries sign of ny (xy) or -nz (yz)
        if (dctx.xy_branch)
        begin
            qa_s = sat16(dctx.ny[15] ? -qa_ext : qa_ext);
            qb_s = sat16(dctx.nx[15] ? qb_ext : -qb_ext);
        end
        else
        begin
            qa_s = sat16(dctx.nz[15] ? qa_ext : -qa_ext);
            qb_s = sat16(dctx.ny[15] ? -qb_ext : qb_ext);
        end
        u_a = qa_s;
        u_b = qb_s;
    end

    logic  tv_reg;
    ctx_t  tc_reg;
    comp_t ta_reg;
    comp_t tb_reg;
    logic  tz_reg;

    // ---- products stage
    logic signed [31:0] p0_reg;
    logic signed [31:0] p1_reg;
    logic signed [31:0] p2_reg;
    logic signed [31:0] p3_reg;
    logic               pv_reg;
    ctx_t               pc_reg;
    comp_t              pa_reg;
    comp_t              pb_reg;
    logic               pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            tv_reg <= dv[DIV_STEPS];
            pv_reg <= tv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tc_reg <= dctx;
            ta_reg <= u_a;
            tb_reg <= u_b;
            tz_reg <= (dl[DIV_STEPS] == '0);
            pc_reg <= tc_reg;
            pa_reg <= ta_reg;
            pb_reg <= tb_reg;
            pz_reg <= tz_reg;
            if (tc_reg.xy_branch)
            begin
                // t0 = a, t1 = b
                p0_reg <= tb_reg * tc_reg.nz;   // t1*n3
                p1_reg <= ta_reg * tc_reg.nz;   // t0*n3
                p2_reg <= tb_reg * tc_reg.nx;   // t1*n1
                p3_reg <= ta_reg * tc_reg.ny;   // t0*n2
            end
            else
            begin
                // t1 = a, t2 = b
                p0_reg <= tb_reg * tc_reg.ny;   // t2*n2
                p1_reg <= ta_reg * tc_reg.nz;   // t1*n3
                p2_reg <= tb_reg * tc_reg.nx;   // t2*n1
                p3_reg <= ta_reg * tc_reg.nx;   // t1*n1
            end
        end
    end

    // ---- final rounding, mode selection, output register
    function automatic comp_t rnd(input logic signed [33:0] p);
        logic signed [47:0] s;
        s = 48'(p) + (48'sd1 <<< (FRAC_BITS - 1));
        return sat16(s >>> FRAC_BITS);
    endfunction

    logic [95:0] res;
    logic        degen;
    comp_t       t2d0;
    logic signed [47:0] ny_ext;

    always_comb
    begin
        res    = '0;
        degen  = 1'b0;
        ny_ext = 48'(pc_reg.ny);
        t2d0   = sat16(-ny_ext);
        if (!pc_reg.three_dim)
        begin
            res[15:0]  = t2d0;
            res[31:16] = pc_reg.nx;
        end
        else if (pz_reg)
            degen = 1'b1;
        else if (pc_reg.xy_branch)
        begin
            res[15:0]  = pa_reg;
            res[31:16] = pb_reg;
            res[63:48] = rnd(-34'(p0_reg));
            res[79:64] = rnd(34'(p1_reg));
            res[95:80] = rnd(34'(p2_reg) - 34'(p3_reg));
        end
        else
        begin
            res[31:16] = pa_reg;
            res[47:32] = pb_reg;
            res[63:48] = rnd(34'(p0_reg) - 34'(p1_reg));
            res[79:64] = rnd(-34'(p2_reg));
            res[95:80] = rnd(34'(p3_reg));
        end
    end

    logic        ov_reg;
    logic [95:0] od_reg;
    logic        ou_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= pv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= res;
            ou_reg <= degen;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
endmodule
`default_nettype wire

@@ rtl/core/tfn_sqrt_cell.sv @@
`default_nettype none
// One digit of the restoring integer square root (two radicand bits per cell)
module tfn_sqrt_cell
#(
    parameter int STEP = 0
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [tfn_pkg::SUM_W-1:0]  in_rem,
    input  wire logic [tfn_pkg::ROOT_W-1:0] in_root,
    input  wire tfn_pkg::ctx_t              in_ctx,
    output logic                            out_valid,
    output logic [tfn_pkg::SUM_W-1:0]       out_rem,
    output logic [tfn_pkg::ROOT_W-1:0]      out_root,
    output tfn_pkg::ctx_t                   out_ctx,
    input  wire logic                       en
);
    import tfn_pkg::*;

    localparam int SH = 2 * (SQ_STEPS - 1 - STEP);

    logic [33:0] trial;
    logic [33:0] rem_w;
    logic        fits;
    logic                  valid_reg;
    logic [SUM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    ctx_t                  ctx_reg;

    // trial = (4*root + 1) << SH against remainder
    always_comb
    begin
        trial = ({16'd0, in_root, 2'b01}) << SH;
        rem_w = 34'(in_rem);
        fits  = rem_w >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= in_ctx;
            if (fits)
            begin
                rem_reg  <= SUM_W'(rem_w - trial);
                root_reg <= {in_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= in_rem;
                root_reg <= {in_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_ctx   = ctx_reg;
endmodule
`default_nettype wire

@@ rtl/core/tfn_div_cell.sv @@
`default_nettype none
// One quotient bit for both normalizing divides (restoring, shared divisor)
module tfn_div_cell
#(
    parameter int STEP = 0
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [tfn_pkg::ROOT_W-1:0] in_len,
    input  wire logic [tfn_pkg::QUO_W-1:0]  in_num_a,
    input  wire logic [tfn_pkg::QUO_W-1:0]  in_num_b,
    input  wire logic [tfn_pkg::QUO_W-1:0]  in_q_a,
    input  wire logic [tfn_pkg::QUO_W-1:0]  in_q_b,
    input  wire tfn_pkg::ctx_t              in_ctx,
    output logic                            out_valid,
    output logic [tfn_pkg::ROOT_W-1:0]      out_len,
    output logic [tfn_pkg::QUO_W-1:0]       out_num_a,
    output logic [tfn_pkg::QUO_W-1:0]       out_num_b,
    output logic [tfn_pkg::QUO_W-1:0]       out_q_a,
    output logic [tfn_pkg::QUO_W-1:0]       out_q_b,
    output tfn_pkg::ctx_t                   out_ctx
);
    import tfn_pkg::*;

    localparam int SH = QUO_W - 1 - STEP;

    logic [QUO_W+ROOT_W-1:0] d_sh;
    logic                    ge_a;
    logic                    ge_b;
    logic                    valid_reg;
    logic [ROOT_W-1:0]       len_reg;
    logic [QUO_W-1:0]        num_a_reg;
    logic [QUO_W-1:0]        num_b_reg;
    logic [QUO_W-1:0]        q_a_reg;
    logic [QUO_W-1:0]        q_b_reg;
    ctx_t                    ctx_reg;

    always_comb
    begin
        d_sh = {{QUO_W{1'b0}}, in_len} << SH;
        ge_a = {{ROOT_W{1'b0}}, in_num_a} >= d_sh;
        ge_b = {{ROOT_W{1'b0}}, in_num_b} >= d_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg   <= in_len;
            ctx_reg   <= in_ctx;
            num_a_reg <= ge_a ? QUO_W'({{ROOT_W{1'b0}}, in_num_a} - d_sh) : in_num_a;
            num_b_reg <= ge_b ? QUO_W'({{ROOT_W{1'b0}}, in_num_b} - d_sh) : in_num_b;
            q_a_reg   <= in_q_a | (QUO_W'(ge_a) << SH);
            q_b_reg   <= in_q_b | (QUO_W'(ge_b) << SH);
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_num_a = num_a_reg;
    assign out_num_b = num_b_reg;
    assign out_q_a   = q_a_reg;
    assign out_q_b   = q_b_reg;
    assign out_ctx   = ctx_reg;
endmodule
`default_nettype wire

@@ rtl/core/tfn_checker.sv @@
`default_nettype none
module tfn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    // stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    // degenerate beats carry all-zero tangents
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 96'd0)
        else $error("degenerate beat with nonzero data");

    // input side is ready whenever the output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free output");

    // nothing comes out of an empty row right after reset
    a_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
endmodule

bind tangent_frame_from_normal_unit tfn_checker u_tfn_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

@@ bench/tangent_frame_checker.sv @@
`default_nettype none
module tangent_frame_checker
#(
    parameter int FRAC_BITS = 14
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [95:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    output int               fail_count,
    output int               pending,
    output int               frames_seen,
    output int               degen_seen
);
    import tfn_pkg::*;

    typedef struct {
        logic [95:0] tangents;
        logic        degen;
    } frame_t;

    frame_t frame_q[$];
    logic   mode_3d;

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // floor square root by bisection
    function automatic longint root_floor(input longint n);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // c / len, ties away from zero
    function automatic longint scaled_div(input longint c, input longint len);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = ((mag << FRAC_BITS) + (len >> 1)) / len;
        return clamp16((c < 0) ? -q : q);
    endfunction

    // drop FRAC_BITS fraction bits, half up
    function automatic longint round_half_up(input longint p);
        return clamp16((p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic frame_t tangent_frame(input logic [47:0] nrm, input logic three);
        frame_t  f;
        longint  n1;
        longint  n2;
        longint  n3;
        longint  len;
        longint  t[6];
        longint  half;
        n1 = longint'($signed(nrm[15:0]));
        n2 = longint'($signed(nrm[31:16]));
        n3 = longint'($signed(nrm[47:32]));
        half = longint'(1) << (FRAC_BITS - 1);
        for (int i = 0; i < 6; i++)
            t[i] = 0;
        f.degen = 1'b0;
        if (!three)
        begin
            t[0] = clamp16(-n2);
            t[1] = n1;
        end
        else if ((n1 < 0 ? -n1 : n1) >= half || (n2 < 0 ? -n2 : n2) >= half)
        begin
            len = root_floor(n1 * n1 + n2 * n2);
            if (len == 0)
                f.degen = 1'b1;
            else
            begin
                t[0] = scaled_div(n2, len);
                t[1] = scaled_div(-n1, len);
                t[3] = round_half_up(-t[1] * n3);
                t[4] = round_half_up(t[0] * n3);
                t[5] = round_half_up(t[1] * n1 - t[0] * n2);
            end
        end
        else
        begin
            len = root_floor(n2 * n2 + n3 * n3);
            if (len == 0)
                f.degen = 1'b1;
            else
            begin
                t[1] = scaled_div(-n3, len);
                t[2] = scaled_div(n2, len);
                t[3] = round_half_up(t[2] * n2 - t[1] * n3);
                t[4] = round_half_up(-t[2] * n1);
                t[5] = round_half_up(t[1] * n1);
            end
        end
        for (int i = 0; i < 6; i++)
            f.tangents[16*i +: 16] = t[i][15:0];
        return f;
    endfunction

    assign pending = frame_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        frame_t exp_f;
        if (!rst_n)
        begin
            mode_3d <= 1'b1;
            frame_q.delete();
            fail_count <= 0;
            frames_seen <= 0;
            degen_seen <= 0;
        end
        else
        begin
            // input beat uses the mode in force before this edge
            if (s_axis_tvalid && s_axis_tready)
                frame_q.push_back(tangent_frame(s_axis_tdata, mode_3d));
            if (cfg_wr_en)
                mode_3d <= cfg_wr_data;
            // output beat
            if (m_axis_tvalid && m_axis_tready)
            begin
                frames_seen <= frames_seen + 1;
                if (m_axis_tuser)
                    degen_seen <= degen_seen + 1;
                if (frame_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected output beat %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_f = frame_q.pop_front();
                    if (exp_f.tangents !== m_axis_tdata || exp_f.degen !== m_axis_tuser)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp %h/%b got %h/%b", exp_f.tangents,
                                     exp_f.degen, m_axis_tdata, m_axis_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ bench/tangent_frame_from_normal_unit_tb.sv @@
`default_nettype none
module tangent_frame_from_normal_unit_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          frames_seen;
    int          degen_seen;
    logic        sink_steady = 1'b0;

    localparam int LATENCY = 53;

    always #5 clk = ~clk;

    tangent_frame_from_normal_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    tangent_frame_checker CHK (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser), .fail_count(fail_count), .pending(pending),
        .frames_seen(frames_seen), .degen_seen(degen_seen)
    );

    // receiver stalls about 16 percent of the time unless told to stay ready
    always @(posedge clk)
        m_axis_tready <= sink_steady || ($urandom_range(99) >= 16);

    // one normal per call; optional idle cycles before it
    task automatic send_normal(input logic [15:0] nx, input logic [15:0] ny,
                               input logic [15:0] nz, input bit may_idle);
        while (may_idle && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {nz, ny, nx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // drop valid right after the last accepted beat, then wait for the pipe
    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_mode(input logic three);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= three;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // mostly unit-length-ish normals, some raw noise
    function automatic logic [15:0] pick_comp(input int sel);
        case (sel)
            0: return 16'($urandom);
            1: return 16'($urandom_range(8191));
            2: return 16'(-$signed(17'($urandom_range(8191))));
            3: return 16'(16384 - $urandom_range(4096));
            default: return 16'(-$signed(17'(16384 - $urandom_range(4096))));
        endcase
    endfunction

    task automatic random_block(input int count, input bit may_idle);
        for (int i = 0; i < count; i++)
            send_normal(pick_comp($urandom_range(4)), pick_comp($urandom_range(4)),
                        pick_comp($urandom_range(4)), may_idle);
    endtask

    task automatic directed_set();
        send_normal(16'h0000, 16'h0000, 16'h0000, 1'b0);  // zero length
        send_normal(16'h4000, 16'h0000, 16'h0000, 1'b0);
        send_normal(16'h0000, 16'h4000, 16'h0000, 1'b0);
        send_normal(16'h0000, 16'h0000, 16'h4000, 1'b0);  // yz branch
        send_normal(16'h0000, 16'h0000, 16'hc000, 1'b0);
        send_normal(16'h8000, 16'h8000, 16'h8000, 1'b0);  // most negative
        send_normal(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_normal(16'h2000, 16'h0000, 16'h1234, 1'b0);  // at threshold
        send_normal(16'h1fff, 16'h1fff, 16'h0000, 1'b0);  // just under, yz branch, nz zero
        send_normal(16'he000, 16'h0001, 16'h0000, 1'b0);
        send_normal(16'h0001, 16'h0000, 16'h0000, 1'b0);  // tiny, degenerate in yz
        send_normal(16'h0000, 16'h0001, 16'hffff, 1'b0);
        send_normal(16'h2d41, 16'h2d41, 16'h0000, 1'b0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3D from reset, then 2D, then 3D again
        directed_set();
        drain_and_idle();
        set_mode(1'b0);
        directed_set();
        drain_and_idle();
        set_mode(1'b1);

        random_block(300, 1'b1);
        drain_and_idle();
        set_mode(1'b0);
        random_block(250, 1'b1);
        drain_and_idle();
        set_mode(1'b1);
        // full-rate stretch, no idling on either side
        sink_steady <= 1'b1;
        random_block(300, 1'b0);
        sink_steady <= 1'b0;
        // sender holds off until the pipe is empty
        drain_and_idle();
        random_block(374, 1'b1);
        drain_and_idle();

        $display("covered %0d beats (%0d degenerate) across 2D and 3D mode phases",
                 frames_seen, degen_seen);
        if (fail_count == 0)
            $display("tangent_frame_from_normal_unit_tb: PASS");
        else
            $display("tangent_frame_from_normal_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tangent_frame_from_normal_unit_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/tfn_pkg.sv
rtl/core/tfn_sqrt_cell.sv
rtl/core/tfn_div_cell.sv
rtl/core/tangent_frame_from_normal_unit.sv
rtl/core/tfn_checker.sv
bench/tangent_frame_checker.sv
bench/tangent_frame_from_normal_unit_tb.sv
